// File: hw/rtl/hdmi_data_island_encoder_assert.svh
// assertion macros for the data island encoder
// sampled on clk_i and disabled while rst_ni is low
`ifndef HDMI_DATA_ISLAND_ENCODER_ASSERT_SVH
`define HDMI_DATA_ISLAND_ENCODER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define HDIE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define HDIE_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) pre |=> post) else $error(msg);
`else
`define HDIE_ASSERT(name, prop, msg)
`define HDIE_ASSERT_NEXT(name, pre, post, msg)
`endif

`endif

// File: hw/rtl/hdie_pkg.sv
`default_nettype none

package hdie_pkg;

  localparam int unsigned NumSub   = 4;
  localparam int unsigned EccLanes = NumSub + 1;

  localparam logic [5:0] LastIdx     = 6'd35;
  localparam logic [5:0] DataFirst   = 6'd2;
  localparam logic [5:0] DataEnd     = 6'd34;
  // first word that reads an ecc bit (header bit 24)
  localparam logic [5:0] EccNeedIdx  = 6'd26;
  localparam logic [9:0] GuardSymbol = 10'h133;
  localparam logic [7:0] EccPoly     = 8'h83;
  localparam logic [2:0] HdrBytes    = 3'd3;
  localparam logic [2:0] SubBytes    = 3'd7;

  typedef struct packed {
    logic [23:0] header_bytes;
    logic [55:0] subpacket_0;
    logic [55:0] subpacket_1;
    logic [55:0] subpacket_2;
    logic [55:0] subpacket_3;
    logic        vsync_pulse;
    logic        hsync_pulse;
  } in_t;

  typedef struct packed {
    logic [29:0] island_word;
    logic        last_word;
  } out_t;

  // one byte of the lsb-first bch shift register
  function automatic logic [7:0] ecc_byte(input logic [7:0] ecc, input logic [7:0] data);
    logic [7:0] r;
    logic       fb;
    r = ecc;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ data[i];
      r  = r >> 1;
      if (fb) begin
        r = r ^ EccPoly;
      end
    end
    return r;
  endfunction

  function automatic logic [9:0] terc4(input logic [3:0] nib);
    logic [9:0] sym;
    case (nib)
      4'h0:    sym = 10'h29C;
      4'h1:    sym = 10'h263;
      4'h2:    sym = 10'h2E4;
      4'h3:    sym = 10'h2E2;
      4'h4:    sym = 10'h171;
      4'h5:    sym = 10'h11E;
      4'h6:    sym = 10'h18E;
      4'h7:    sym = 10'h13C;
      4'h8:    sym = 10'h2CC;
      4'h9:    sym = 10'h139;
      4'hA:    sym = 10'h19C;
      4'hB:    sym = 10'h2C6;
      4'hC:    sym = 10'h28E;
      4'hD:    sym = 10'h271;
      4'hE:    sym = 10'h163;
      default: sym = 10'h2C3;
    endcase
    return sym;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/hdie_ecc_lane.sv
`default_nettype none

module hdie_ecc_lane (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [2:0]  num_bytes_i,
  input  wire logic [55:0] data_i,
  output logic      [7:0]  ecc_o,
  output logic             done_o
);

  logic [55:0] data_q, data_d;
  logic [7:0]  ecc_q, ecc_d;
  logic [2:0]  cnt_q, cnt_d;

  always_comb begin
    data_d = data_q;
    ecc_d  = ecc_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      data_d = data_i;
      ecc_d  = 8'h00;
      cnt_d  = num_bytes_i;
    end else if (cnt_q != 3'd0) begin
      // one byte per cycle, lowest byte first
      ecc_d  = hdie_pkg::ecc_byte(ecc_q, data_q[7:0]);
      data_d = data_q >> 8;
      cnt_d  = cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    ecc_q  <= ecc_d;
  end

  assign ecc_o  = ecc_q;
  assign done_o = (cnt_q == 3'd0);

endmodule

`default_nettype wire

// File: hw/rtl/hdmi_data_island_encoder.sv
`default_nettype none

// Data island encoder: each accepted request is one packet (header, four
// subpackets, sync flags) and yields 36 words of 30 bits, one per cycle while
// the output is not stalled: two guard words, 32 TERC4 words, two guard words,
// with last_word set on the 36th. The sustained packet rate is set by the 36
// words each packet yields at one word per cycle. Five ECC lanes (header and
// each subpacket) work side by side, one byte per cycle, and finish well
// before the first word that carries ECC bits. A one-packet input buffer takes
// the next request while the current island is still being sent, so islands
// follow each other with no gap. The sync polarity bit is sampled when a
// packet starts and should only be written while the block is idle.

`include "hdmi_data_island_encoder_assert.svh"

module hdmi_data_island_encoder (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_we_i,
  input  wire logic           cfg_data_i,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire hdie_pkg::in_t  in_req_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output hdie_pkg::out_t      out_req_o
);

  logic           sync_pos_q;
  logic           pend_valid_q, pend_valid_d;
  hdie_pkg::in_t  pend_q;
  logic           active_q, active_d;
  logic [5:0]     idx_q, idx_d;
  logic [1:0]     hv_q;
  logic [23:0]    hdr_q;
  logic [55:0]    sub_q [hdie_pkg::NumSub];
  logic           out_valid_q, out_valid_d;
  hdie_pkg::out_t out_q;

  logic           in_fire, out_free, gen_fire, gen_last, load;
  logic [1:0]     hv_new;

  logic [55:0]    lane_data [hdie_pkg::EccLanes];
  logic [2:0]     lane_bytes [hdie_pkg::EccLanes];
  logic [7:0]     lane_ecc [hdie_pkg::EccLanes];
  logic [hdie_pkg::EccLanes-1:0] lane_done;

  logic [31:0]    hdr_full;
  logic [63:0]    sub_full [hdie_pkg::NumSub];
  logic [5:0]     s_ext;
  logic [4:0]     s;
  logic           is_guard;
  logic [3:0]     n0, n1, n2;
  logic [9:0]     l0, l1, l2;
  hdie_pkg::out_t word;

  // handshake
  assign in_stall_o = pend_valid_q;
  assign in_fire    = in_valid_i && !pend_valid_q;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign gen_fire   = active_q && out_free;
  assign gen_last   = gen_fire && (idx_q == hdie_pkg::LastIdx);
  assign load       = pend_valid_q && (!active_q || gen_last);

  assign hv_new = {pend_q.vsync_pulse == sync_pos_q, pend_q.hsync_pulse == sync_pos_q};

  // ecc lanes
  assign lane_data[0]  = {32'd0, pend_q.header_bytes};
  assign lane_data[1]  = pend_q.subpacket_0;
  assign lane_data[2]  = pend_q.subpacket_1;
  assign lane_data[3]  = pend_q.subpacket_2;
  assign lane_data[4]  = pend_q.subpacket_3;
  assign lane_bytes[0] = hdie_pkg::HdrBytes;

  for (genvar g = 0; g < hdie_pkg::EccLanes; g++) begin : g_lane
    if (g > 0) begin : g_sub_bytes
      assign lane_bytes[g] = hdie_pkg::SubBytes;
    end
    hdie_ecc_lane u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .start_i     (load),
      .num_bytes_i (lane_bytes[g]),
      .data_i      (lane_data[g]),
      .ecc_o       (lane_ecc[g]),
      .done_o      (lane_done[g])
    );
  end

  // merge: pick the bits for this word and encode three lanes
  always_comb begin
    hdr_full = {lane_ecc[0], hdr_q};
    for (int k = 0; k < hdie_pkg::NumSub; k++) begin
      sub_full[k] = {lane_ecc[k+1], sub_q[k]};
    end
    s_ext    = idx_q - hdie_pkg::DataFirst;
    s        = s_ext[4:0];
    is_guard = (idx_q < hdie_pkg::DataFirst) || (idx_q >= hdie_pkg::DataEnd);
    n0       = {s != 5'd0, hdr_full[s], hv_q};
    for (int k = 0; k < hdie_pkg::NumSub; k++) begin
      n1[k] = sub_full[k][{s, 1'b0}];
      n2[k] = sub_full[k][{s, 1'b1}];
    end
    if (is_guard) begin
      l0 = hdie_pkg::terc4({2'b11, hv_q});
      l1 = hdie_pkg::GuardSymbol;
      l2 = hdie_pkg::GuardSymbol;
    end else begin
      l0 = hdie_pkg::terc4(n0);
      l1 = hdie_pkg::terc4(n1);
      l2 = hdie_pkg::terc4(n2);
    end
    word.island_word = {l2, l1, l0};
    word.last_word   = (idx_q == hdie_pkg::LastIdx);
  end

  always_comb begin
    pend_valid_d = pend_valid_q;
    if (in_fire) begin
      pend_valid_d = 1'b1;
    end else if (load) begin
      pend_valid_d = 1'b0;
    end

    active_d = active_q;
    if (load) begin
      active_d = 1'b1;
    end else if (gen_last) begin
      active_d = 1'b0;
    end

    idx_d = idx_q;
    if (load || gen_last) begin
      idx_d = 6'd0;
    end else if (gen_fire) begin
      idx_d = idx_q + 6'd1;
    end

    out_valid_d = out_valid_q && out_stall_i;
    if (gen_fire) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_pos_q   <= 1'b0;
      pend_valid_q <= 1'b0;
      active_q     <= 1'b0;
      idx_q        <= 6'd0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        sync_pos_q <= cfg_data_i;
      end
      pend_valid_q <= pend_valid_d;
      active_q     <= active_d;
      idx_q        <= idx_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pend_q <= in_req_i;
    end
    if (load) begin
      hv_q     <= hv_new;
      hdr_q    <= pend_q.header_bytes;
      sub_q[0] <= pend_q.subpacket_0;
      sub_q[1] <= pend_q.subpacket_1;
      sub_q[2] <= pend_q.subpacket_2;
      sub_q[3] <= pend_q.subpacket_3;
    end
    if (gen_fire) begin
      out_q <= word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  `HDIE_ASSERT(a_idle_idx, !active_q |-> idx_q == 6'd0, "word index not zero while idle")
  `HDIE_ASSERT(a_ecc_ready, active_q && idx_q >= hdie_pkg::EccNeedIdx |-> &lane_done, "ecc not ready")
  `HDIE_ASSERT(a_idx_range, active_q |-> idx_q <= hdie_pkg::LastIdx, "word index out of range")
  `HDIE_ASSERT_NEXT(a_last_out, gen_last, out_valid_q && out_q.last_word, "last word lost")

endmodule

`default_nettype wire
